// ===== sv/linear_blend_vertex_skinning_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef LINEAR_BLEND_VERTEX_SKINNING_UNIT_DEFINES_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LBS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lbs_pkg.sv =====
package lbs_pkg;

	localparam int MAX_JOINTS = 64;
	localparam int MAT_ELEMS  = 12;
	localparam int MEM_DEPTH  = MAX_JOINTS * MAT_ELEMS;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SKIN = 1'b1;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [63:0] acc_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic start;
		logic is_sqrt;
	} iter_cmd_t;

	// Round half up from Q.30 to Q.16 and saturate to 32 bits.
	function automatic q16_t round_sat(input acc_t x);
		logic signed [64:0] t;
		t = ($signed({x[63], x}) + 65'sd8192) >>> 14;
		if (t > 65'sd2147483647) begin
			round_sat = 32'sh7fffffff;
		end else if (t < -65'sd2147483648) begin
			round_sat = 32'sh80000000;
		end else begin
			round_sat = t[31:0];
		end
	endfunction

	// Add with saturation at the 64-bit signed limits.
	function automatic acc_t sat_add(input acc_t a, input acc_t b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s[64] != s[63]) begin
			sat_add = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end else begin
			sat_add = s[63:0];
		end
	endfunction

	function automatic logic [63:0] mag64(input acc_t v);
		mag64 = v[63] ? (64'd0 - v) : v;
	endfunction

endpackage

// ===== sv/linear_blend_vertex_skinning_unit.sv =====
// Channel  | Handshake             | Payload
// cfg      | cfg_valid / cfg_ready | cfg_data (joint_count)
// in       | in_valid / in_ready   | command, joint, element, value, weight, pos, nrm, last
// out      | out_valid / out_ready | out_pos_x/y/z, out_nrm_x/y/z, skinned
//
// Load items and skipped influences that are not last leave the block idle and ready.
// An applied influence works through the three matrix rows: each row needs a fetch of
// its four words from the matrix memory and eight passes through the one shared multiplier.
// A last item then uses the shared divide/square-root unit, which makes one bit per cycle
// (three 64-step divides if the total weight is nonzero; if the normal sums are nonzero,
// one 32-step root and three more divides, after shifting the sums into range bit by bit).
// Reset is asynchronous and clears the accumulators, joint_count and out_valid;
// the matrix memory is not cleared. A waiting result does not stop the next item.
module linear_blend_vertex_skinning_unit import lbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [5:0]  joint,
	input  logic [3:0]  element,
	input  q16_t        value,
	input  logic signed [15:0] weight,
	input  q16_t        pos_x,
	input  q16_t        pos_y,
	input  q16_t        pos_z,
	input  q16_t        nrm_x,
	input  q16_t        nrm_y,
	input  q16_t        nrm_z,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output q16_t        out_pos_x,
	output q16_t        out_pos_y,
	output q16_t        out_pos_z,
	output q16_t        out_nrm_x,
	output q16_t        out_nrm_y,
	output q16_t        out_nrm_z,
	output logic        skinned
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_FETCH   = 4'd1;
	localparam logic [3:0] S_MUL     = 4'd2;
	localparam logic [3:0] S_ACC     = 4'd3;
	localparam logic [3:0] S_FIN     = 4'd4;
	localparam logic [3:0] S_PLAUNCH = 4'd5;
	localparam logic [3:0] S_PWAIT   = 4'd6;
	localparam logic [3:0] S_NMAX    = 4'd7;
	localparam logic [3:0] S_NORM    = 4'd8;
	localparam logic [3:0] S_SQMUL   = 4'd9;
	localparam logic [3:0] S_SQACC   = 4'd10;
	localparam logic [3:0] S_SQRT    = 4'd11;
	localparam logic [3:0] S_SQWAIT  = 4'd12;
	localparam logic [3:0] S_NLAUNCH = 4'd13;
	localparam logic [3:0] S_NWAIT   = 4'd14;
	localparam logic [3:0] S_OUT     = 4'd15;

	logic [3:0]  state_q;
	logic [6:0]  joint_count_q;

	// Accumulators: Q34.30 sums and the Q10.14 total weight.
	acc_t        pos_sum_q [3];
	acc_t        nrm_sum_q [3];
	logic [23:0] ws_q;

	// Latched influence.
	q16_t        pos_q [3];
	q16_t        nrm_q [3];
	logic signed [15:0] w_q;
	logic        last_q;
	addr_t       base_q;

	// Row transform working registers.
	logic [1:0]  row_q;
	logic [2:0]  step_q;
	logic [2:0]  fcnt_q;
	q16_t        mrow_q [4];
	acc_t        accp_q;
	acc_t        accn_q;
	q16_t        tp_q;
	q16_t        tn_q;

	// Finishing registers.
	q16_t        res_pos_q [3];
	q16_t        res_nrm_q [3];
	logic [63:0] a_q [3];
	logic [63:0] mx_q;
	logic [63:0] sq_q;
	logic [31:0] len_q;
	logic        skinned_q;

	iter_cmd_t   iter_cmd_q;
	logic [63:0] iter_num_q;
	logic [31:0] iter_den_q;
	logic        iter_done;
	logic [63:0] iter_res;

	logic        out_valid_q;
	q16_t        out_pos_q [3];
	q16_t        out_nrm_q [3];
	logic        out_skinned_q;

	logic        in_acc;
	logic        apply;
	logic        ram_we;
	addr_t       wr_addr;
	addr_t       joint_base;
	addr_t       rd_addr;
	q16_t        rd_data;
	q16_t        mul_a;
	q16_t        mul_b;
	acc_t        prod;
	acc_t        prod_sh;
	logic [24:0] ws_nx;
	logic [63:0] nmag [3];
	logic [63:0] nmax01;
	logic [63:0] nmax;
	logic        out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Matrix memory: loads write directly from the input port.
	assign joint_base = addr_t'(joint) * addr_t'(MAT_ELEMS);
	assign wr_addr    = joint_base + addr_t'(element);
	assign ram_we     = in_acc && (command == CMD_LOAD) && (int'(element) < MAT_ELEMS)
		&& (int'(joint) < MAX_JOINTS);
	assign rd_addr    = base_q + addr_t'({row_q, 2'b00}) + addr_t'(fcnt_q[1:0]);

	assign apply = (weight > 16'sd0) && ({1'b0, joint} < joint_count_q)
		&& (int'(joint) < MAX_JOINTS);

	lbs_mat_ram u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Shared multiplier. Steps 0..5 form the row dot products (position and normal
	// alternate per column), steps 6 and 7 weight the two transformed values. The
	// sum-of-squares pass for the normal length reuses it.
	always_comb begin
		if (state_q == S_SQMUL) begin
			mul_a = $signed(a_q[row_q][31:0]);
			mul_b = $signed(a_q[row_q][31:0]);
		end else begin
			case (step_q)
				3'd6: begin
					mul_a = tp_q;
					mul_b = 32'(w_q);
				end
				3'd7: begin
					mul_a = tn_q;
					mul_b = 32'(w_q);
				end
				default: begin
					mul_a = mrow_q[step_q[2:1]];
					mul_b = step_q[0] ? nrm_q[step_q[2:1]] : pos_q[step_q[2:1]];
				end
			endcase
		end
	end

	lbs_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod)
	);

	lbs_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (iter_cmd_q),
		.num    (iter_num_q),
		.den    (iter_den_q),
		.done   (iter_done),
		.result (iter_res)
	);

	assign prod_sh = prod >>> 2;
	assign ws_nx   = {1'b0, ws_q} + {10'b0, w_q[14:0]};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nmag[i] = mag64(nrm_sum_q[i]);
		end
		nmax01 = (nmag[0] > nmag[1]) ? nmag[0] : nmag[1];
		nmax   = (nmax01 > nmag[2]) ? nmax01 : nmag[2];
	end

	// Control and accumulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			joint_count_q <= '0;
			ws_q          <= '0;
			out_valid_q   <= 1'b0;
			iter_cmd_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				pos_sum_q[i] <= '0;
				nrm_sum_q[i] <= '0;
			end
		end else begin
			iter_cmd_q <= '0;
			if (cfg_valid) begin
				joint_count_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && command == CMD_SKIN) begin
						if (apply) begin
							state_q <= S_FETCH;
						end else if (last) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FETCH: begin
					if (fcnt_q == 3'd4) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (step_q == 3'd6) begin
						pos_sum_q[row_q] <= sat_add(pos_sum_q[row_q], prod);
					end
					if (step_q == 3'd7) begin
						nrm_sum_q[row_q] <= sat_add(nrm_sum_q[row_q], prod);
						if (row_q == 2'd2) begin
							ws_q    <= ws_nx[24] ? 24'hFFFFFF : ws_nx[23:0];
							state_q <= last_q ? S_FIN : S_IDLE;
						end else begin
							state_q <= S_FETCH;
						end
					end else begin
						state_q <= S_MUL;
					end
				end
				S_FIN: begin
					state_q <= (ws_q == 24'd0) ? S_OUT : S_PLAUNCH;
				end
				S_PLAUNCH: begin
					iter_cmd_q <= '{start: 1'b1, is_sqrt: 1'b0};
					state_q    <= S_PWAIT;
				end
				S_PWAIT: begin
					if (iter_done) begin
						state_q <= (row_q == 2'd2) ? S_NMAX : S_PLAUNCH;
					end
				end
				S_NMAX: begin
					state_q <= S_NORM;
				end
				S_NORM: begin
					if (mx_q == 64'd0) begin
						state_q <= S_OUT;
					end else if (mx_q[63:30] == '0 && mx_q[29]) begin
						state_q <= S_SQMUL;
					end
				end
				S_SQMUL: begin
					state_q <= S_SQACC;
				end
				S_SQACC: begin
					state_q <= (row_q == 2'd2) ? S_SQRT : S_SQMUL;
				end
				S_SQRT: begin
					iter_cmd_q <= '{start: 1'b1, is_sqrt: 1'b1};
					state_q    <= S_SQWAIT;
				end
				S_SQWAIT: begin
					if (iter_done) begin
						state_q <= S_NLAUNCH;
					end
				end
				S_NLAUNCH: begin
					iter_cmd_q <= '{start: 1'b1, is_sqrt: 1'b0};
					state_q    <= S_NWAIT;
				end
				S_NWAIT: begin
					if (iter_done) begin
						state_q <= (row_q == 2'd2) ? S_OUT : S_NLAUNCH;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						ws_q        <= '0;
						for (int i = 0; i < 3; i++) begin
							pos_sum_q[i] <= '0;
							nrm_sum_q[i] <= '0;
						end
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && command == CMD_SKIN) begin
					pos_q[0] <= pos_x;
					pos_q[1] <= pos_y;
					pos_q[2] <= pos_z;
					nrm_q[0] <= nrm_x;
					nrm_q[1] <= nrm_y;
					nrm_q[2] <= nrm_z;
					w_q      <= weight;
					last_q   <= last;
					base_q   <= joint_base;
					row_q    <= '0;
					fcnt_q   <= '0;
				end
			end
			S_FETCH: begin
				// Read data arrives in the cycle after its address.
				if (fcnt_q != 3'd0) begin
					mrow_q[2'(fcnt_q - 3'd1)] <= rd_data;
				end
				if (fcnt_q == 3'd4) begin
					accp_q <= acc_t'(rd_data) <<< 30;
					accn_q <= '0;
					step_q <= '0;
				end else begin
					fcnt_q <= fcnt_q + 3'd1;
				end
			end
			S_ACC: begin
				if (step_q < 3'd6) begin
					if (step_q[0]) begin
						accn_q <= accn_q + prod_sh;
					end else begin
						accp_q <= accp_q + prod_sh;
					end
				end
				if (step_q == 3'd4) begin
					tp_q <= round_sat(accp_q + prod_sh);
				end
				if (step_q == 3'd5) begin
					tn_q <= round_sat(accn_q + prod_sh);
				end
				if (step_q == 3'd7) begin
					row_q  <= row_q + 2'd1;
					fcnt_q <= '0;
				end
				step_q <= step_q + 3'd1;
			end
			S_FIN: begin
				row_q     <= '0;
				skinned_q <= (ws_q != 24'd0);
				for (int i = 0; i < 3; i++) begin
					res_pos_q[i] <= pos_q[i];
					res_nrm_q[i] <= nrm_q[i];
				end
			end
			S_PLAUNCH: begin
				iter_num_q <= mag64(pos_sum_q[row_q]) + {41'b0, ws_q[23:1]};
				iter_den_q <= {8'b0, ws_q};
			end
			S_PWAIT: begin
				if (iter_done) begin
					if (pos_sum_q[row_q][63]) begin
						res_pos_q[row_q] <= (iter_res > 64'h80000000) ? 32'sh80000000
							: 32'(64'd0 - iter_res);
					end else begin
						res_pos_q[row_q] <= (iter_res > 64'h7FFFFFFF) ? 32'sh7fffffff
							: iter_res[31:0];
					end
					row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
				end
			end
			S_NMAX: begin
				for (int i = 0; i < 3; i++) begin
					a_q[i] <= nmag[i];
				end
				mx_q <= nmax;
			end
			S_NORM: begin
				// Bring the largest magnitude into [2^29, 2^30), one bit per cycle.
				if (mx_q[63:30] != '0) begin
					mx_q <= mx_q >> 1;
					for (int i = 0; i < 3; i++) begin
						a_q[i] <= a_q[i] >> 1;
					end
				end else if (!mx_q[29]) begin
					mx_q <= mx_q << 1;
					for (int i = 0; i < 3; i++) begin
						a_q[i] <= a_q[i] << 1;
					end
				end else begin
					sq_q  <= '0;
					row_q <= '0;
				end
			end
			S_SQACC: begin
				sq_q  <= sq_q + prod;
				row_q <= (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
			end
			S_SQRT: begin
				iter_num_q <= sq_q;
				iter_den_q <= '0;
			end
			S_SQWAIT: begin
				if (iter_done) begin
					len_q <= iter_res[31:0];
				end
			end
			S_NLAUNCH: begin
				iter_num_q <= {a_q[row_q][47:0], 16'b0} + {33'b0, len_q[31:1]};
				iter_den_q <= len_q;
			end
			S_NWAIT: begin
				if (iter_done) begin
					res_nrm_q[row_q] <= nrm_sum_q[row_q][63] ? 32'(64'd0 - iter_res)
						: iter_res[31:0];
					row_q <= row_q + 2'd1;
				end
			end
			S_OUT: begin
				if (out_free) begin
					for (int i = 0; i < 3; i++) begin
						out_pos_q[i] <= res_pos_q[i];
						out_nrm_q[i] <= res_nrm_q[i];
					end
					out_skinned_q <= skinned_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_pos_x = out_pos_q[0];
	assign out_pos_y = out_pos_q[1];
	assign out_pos_z = out_pos_q[2];
	assign out_nrm_x = out_nrm_q[0];
	assign out_nrm_y = out_nrm_q[1];
	assign out_nrm_z = out_nrm_q[2];
	assign skinned   = out_skinned_q;

endmodule

// ===== sv/lbs_mat_ram.sv =====
module lbs_mat_ram import lbs_pkg::*; (
	input  logic        clk,
	input  logic        wr_en,
	input  addr_t       wr_addr,
	input  q16_t        wr_data,
	input  addr_t       rd_addr,
	output q16_t        rd_data
);

	q16_t mem [MEM_DEPTH];
	q16_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/lbs_mul.sv =====
module lbs_mul import lbs_pkg::*; (
	input  logic clk,
	input  q16_t a,
	input  q16_t b,
	output acc_t prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule

// ===== sv/lbs_iter.sv =====
module lbs_iter import lbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  iter_cmd_t   cmd,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [63:0] result
);

	// One shift-subtract step per cycle: a quotient bit or a root bit.
	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic        sqrt_q;
	logic [63:0] num_q;
	logic [31:0] den_q;
	logic [33:0] rem_q;
	logic [63:0] res_q;

	logic [33:0] shifted;
	logic [33:0] trial;
	logic        ge;
	logic [33:0] rem_nx;

	always_comb begin
		shifted = sqrt_q ? {rem_q[31:0], num_q[63:62]} : {rem_q[32:0], num_q[63]};
		trial   = sqrt_q ? {res_q[31:0], 2'b01} : {2'b00, den_q};
		ge      = shifted >= trial;
		rem_nx  = ge ? (shifted - trial) : shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= cmd.is_sqrt ? 6'd31 : 6'd63;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sqrt_q <= cmd.is_sqrt;
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			res_q  <= '0;
		end else if (busy_q) begin
			num_q <= sqrt_q ? {num_q[61:0], 2'b00} : {num_q[62:0], 1'b0};
			rem_q <= rem_nx;
			res_q <= {res_q[62:0], ge};
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ===== sv/lbs_checker.sv =====
`include "linear_blend_vertex_skinning_unit_defines.svh"

module lbs_checker import lbs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        command,
	input logic        last,
	input logic        out_valid,
	input logic        out_ready,
	input q16_t        out_pos_x,
	input logic        skinned
);

	`LBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_pos_x) && $stable(skinned), "result changed while stalled")
	`LBS_ASSERT_NEXT(a_load_one_cycle, in_valid && in_ready && command == CMD_LOAD, in_ready, "load item did not complete in one cycle")
	`LBS_ASSERT_NEXT(a_skin_busy, in_valid && in_ready && command == CMD_SKIN && last, !in_ready, "final influence item did not occupy the block")
	`LBS_ASSERT_NEXT(a_no_result_midvertex, !out_valid && in_valid && in_ready && command == CMD_SKIN && !last, !out_valid, "result without a last influence")

endmodule

bind linear_blend_vertex_skinning_unit lbs_checker u_lbs_checker (.*);
